// File: rtl/asca_pkg.sv
// Shared types and constants of the ADC scan channel averager.
package asca_pkg;

  // Store geometry and sample format
  localparam int unsigned NUM_CHANNELS  = 16;
  localparam int unsigned HISTORY_DEPTH = 8;
  localparam int unsigned SAMPLE_BITS   = 10;

  localparam int unsigned CH_BITS    = $clog2(NUM_CHANNELS);
  localparam int unsigned SLOT_BITS  = $clog2(HISTORY_DEPTH);
  localparam int unsigned ADDR_BITS  = CH_BITS + SLOT_BITS;
  localparam int unsigned ENTRIES    = NUM_CHANNELS * HISTORY_DEPTH;
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + SLOT_BITS;
  localparam int unsigned MASK_BITS  = 16;

  // Configuration port
  localparam int unsigned PADDR_BITS = 3;
  localparam int unsigned PDATA_BITS = 32;
  localparam logic [PADDR_BITS-1:0] REG_ENABLED_MASK_ADDR = 3'h0;

  // Input item modes
  localparam logic MODE_CONVERSION = 1'b0;
  localparam logic MODE_READ       = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [CH_BITS-1:0]     channel;
  } in_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0]     target_channel;
    logic [SAMPLE_BITS-1:0] passed_value;
    logic [SAMPLE_BITS-1:0] average;
    logic                   accepted;
    logic                   round_done;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

// File: rtl/adc_scan_channel_averager_unit.sv
// ADC scan channel averager: scan distribution, sample history store and averaging.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): each transaction is either a
// scanned conversion (mode 0), written to the next enabled channel's history ring if
// any, or a read (mode 1), which returns the mean of that channel's stored samples.
// Output channel (out_valid_o/out_ready_i, out_data_o): one result per input item,
// in order. An APB port holds enabled_mask at address 0; write it only while idle.
//
// Sequencing: a conversion is stored and its result registered when accepted; the
// result passes to the output register from the finish state. A read walks the
// channel's 8 history entries through the single read port of the sample memory,
// one entry per cycle in the sum state, adds the last entry in the drain state and
// passes its result on from the finish state. A disabled channel's read goes to
// finish at once, like a conversion. Input waits until the finish state is left.
//
// Reset clears the mask, the scan position, the slot index and the per-entry valid
// bits, so every stored sample reads as zero until written; no clearing pass.
// When the receiver stalls, the result waits in the output register while the next
// item is taken and processed; that item's result then waits internally and the
// input is not ready again until the output register frees up.
module adc_scan_channel_averager_unit
  import asca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  // Control state
  state_e                 state_q, state_d;
  logic [MASK_BITS-1:0]   mask_q;
  logic [CH_BITS-1:0]     scan_pos_q, scan_pos_d;
  logic [SLOT_BITS-1:0]   slot_q, slot_d;
  logic [SLOT_BITS-1:0]   cnt_q;
  logic                   rd_vld_q;
  logic                   out_valid_q;
  logic [ENTRIES-1:0]     entry_vld_q;
  logic                   mem_rvld_q;

  // Datapath registers
  logic [CH_BITS-1:0]     chan_q;
  logic [SUM_BITS-1:0]    acc_q;
  out_item_t              res_q, res_d;
  out_item_t              out_q;
  logic [SAMPLE_BITS-1:0] mem_rdata_q;

  logic [SAMPLE_BITS-1:0] mem_q [ENTRIES];

  // Strobes
  logic                   in_fire;
  logic                   out_free;
  logic                   mem_we;
  logic                   res_we;
  logic                   load_out;
  logic [ADDR_BITS-1:0]   waddr;
  logic [ADDR_BITS-1:0]   raddr;
  logic                   cfg_we;

  // Scan target search
  logic [MASK_BITS-1:0]   above_mask;
  logic [MASK_BITS-1:0]   cand_mask;
  logic [MASK_BITS-1:0]   low_bit;
  logic [CH_BITS-1:0]     tgt_ch;
  logic                   has_tgt;
  logic                   last_in_round;
  logic                   rd_enabled;

  logic [SAMPLE_BITS-1:0] rd_word;
  logic [SUM_BITS-1:0]    acc_sum;

  // Input is taken only in the idle state
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // APB register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_ENABLED_MASK_ADDR);
  always_comb begin
    prdata = '0;
    if (paddr == REG_ENABLED_MASK_ADDR) begin
      prdata = PDATA_BITS'(mask_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we) begin
      mask_q <= pwdata[MASK_BITS-1:0];
    end
  end

  // Next enabled channel at or above the scan position, else wrap to the lowest
  always_comb begin
    above_mask = mask_q & ({MASK_BITS{1'b1}} << scan_pos_q);
    cand_mask  = (|above_mask) ? above_mask : mask_q;
    low_bit    = cand_mask & (~cand_mask + MASK_BITS'(1));
    tgt_ch     = '0;
    for (int i = 0; i < MASK_BITS; i++) begin
      if (low_bit[i]) begin
        tgt_ch = tgt_ch | CH_BITS'(i);
      end
    end
    has_tgt       = |mask_q;
    last_in_round = (mask_q & ~(low_bit | (low_bit - MASK_BITS'(1)))) == '0;
  end

  assign rd_enabled = mask_q[in_data_i.channel];

  // Read data of a never written entry counts as zero
  assign rd_word = mem_rvld_q ? mem_rdata_q : '0;
  assign acc_sum = acc_q + SUM_BITS'(rd_word);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == MODE_READ && rd_enabled) begin
            state_d = ST_SUM;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SUM: begin
        if (cnt_q == SLOT_BITS'(HISTORY_DEPTH - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_we     = 1'b0;
    res_we     = 1'b0;
    load_out   = 1'b0;
    res_d      = '0;
    scan_pos_d = scan_pos_q;
    slot_d     = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == MODE_CONVERSION) begin
            res_we = 1'b1;
            if (has_tgt) begin
              mem_we               = 1'b1;
              res_d.target_channel = tgt_ch;
              res_d.passed_value   = in_data_i.sample_value;
              res_d.accepted       = 1'b1;
              res_d.round_done     = last_in_round;
              if (last_in_round) begin
                scan_pos_d = '0;
                slot_d     = (slot_q == SLOT_BITS'(HISTORY_DEPTH - 1)) ? '0
                                                                      : slot_q + 1'b1;
              end else begin
                scan_pos_d = tgt_ch + 1'b1;
              end
            end
          end else if (!rd_enabled) begin
            res_we               = 1'b1;
            res_d.target_channel = in_data_i.channel;
          end
        end
      end
      ST_DRAIN: begin
        res_we               = 1'b1;
        res_d.target_channel = chan_q;
        res_d.average        = acc_sum[SUM_BITS-1:SLOT_BITS];
        res_d.accepted       = 1'b1;
      end
      ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  assign waddr = {tgt_ch, slot_q};
  assign raddr = {chan_q, cnt_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_pos_q  <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      entry_vld_q <= '0;
      mem_rvld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_pos_q <= scan_pos_d;
      slot_q     <= slot_d;
      rd_vld_q   <= (state_q == ST_SUM);
      mem_rvld_q <= entry_vld_q[raddr];
      if (state_q == ST_SUM) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (mem_we) begin
        entry_vld_q[waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= in_data_i.sample_value;
    end
    mem_rdata_q <= mem_q[raddr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chan_q <= in_data_i.channel;
      acc_q  <= '0;
    end else if (rd_vld_q) begin
      acc_q  <= acc_sum;
    end
    if (res_we) begin
      res_q <= res_d;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer and the store
  a_no_write_while_summing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE)
    else $error("sample write outside idle state");

  a_read_data_only_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SUM || state_q == ST_DRAIN))
    else $error("read data returned outside the history walk");

  a_round_end_resets_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && last_in_round) |=> (scan_pos_q == '0 && slot_q != $past(slot_q)))
    else $error("round end did not restart scan and advance slot");

  a_done_implies_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.round_done && !out_data_o.accepted))
    else $error("round_done set on an item that did not take effect");

  a_drain_follows_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> $past(state_q) == ST_SUM)
    else $error("drain entered without a history walk");

endmodule

// File: tb/sv/adc_scan_channel_averager_unit_tb.sv
// Self-checking testbench of the ADC scan channel averager: directed table, random scans.
module adc_scan_channel_averager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asca_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned SEG_ITEMS      = 27;
  localparam int unsigned ZERO_SEG_ITEMS = 8;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] cfg;
    in_item_t    item;
    bit          typed;
    out_item_t   typed_res;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  // Shadow copy of the block state
  logic [MASK_BITS-1:0]   mask_model;
  logic [SAMPLE_BITS-1:0] hist_model [NUM_CHANNELS][HISTORY_DEPTH];
  int unsigned            scan_model;
  logic [SLOT_BITS-1:0]   slot_model;

  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];

  int errors        = 0;
  int results_seen  = 0;
  int reads_sent    = 0;
  int convs_sent    = 0;
  int mask_settings = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 45;

  adc_scan_channel_averager_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Lowest enabled channel at or above start, NUM_CHANNELS if none
  function automatic int unsigned next_enabled_from(int unsigned start);
    int unsigned c;
    for (c = start; c < NUM_CHANNELS; c++) begin
      if (mask_model[c]) return c;
    end
    return NUM_CHANNELS;
  endfunction

  // Expected result of one item; updates the shadow state
  function automatic out_item_t predict_item(in_item_t it);
    out_item_t   r;
    int unsigned c;
    int unsigned sum;
    r = '0;
    if (it.mode == MODE_CONVERSION) begin
      if (mask_model != '0) begin
        c = next_enabled_from(scan_model);
        if (c >= NUM_CHANNELS) c = next_enabled_from(0);
        hist_model[c][slot_model] = it.sample_value;
        r.target_channel = CH_BITS'(c);
        r.passed_value   = it.sample_value;
        r.accepted       = 1'b1;
        if (next_enabled_from(c + 1) >= NUM_CHANNELS) begin
          r.round_done = 1'b1;
          scan_model   = 0;
          slot_model   = slot_model + 1'b1;
        end else begin
          scan_model = c + 1;
        end
      end
    end else begin
      r.target_channel = it.channel;
      if (mask_model[it.channel]) begin
        sum = 0;
        for (int k = 0; k < HISTORY_DEPTH; k++) sum += hist_model[it.channel][k];
        r.average  = SAMPLE_BITS'(sum / HISTORY_DEPTH);
        r.accepted = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic in_item_t conv(logic [SAMPLE_BITS-1:0] v);
    in_item_t it;
    it = '0;
    it.mode = MODE_CONVERSION;
    it.sample_value = v;
    return it;
  endfunction

  function automatic in_item_t rd(logic [CH_BITS-1:0] ch);
    in_item_t it;
    it = '0;
    it.mode = MODE_READ;
    it.channel = ch;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.mode = ($urandom_range(99) < 70) ? MODE_CONVERSION : MODE_READ;
    pick = $urandom_range(9);
    if (pick == 0) it.sample_value = '0;
    else if (pick == 1) it.sample_value = '1;
    else it.sample_value = SAMPLE_BITS'($urandom_range(1023));
    it.channel = CH_BITS'($urandom_range(NUM_CHANNELS - 1));
    return it;
  endfunction

  task automatic add_cfg(logic [31:0] v);
    dir_rows.push_back('{ROW_CFG, v, '0, 1'b0, '0});
  endtask

  task automatic add_item(in_item_t it);
    dir_rows.push_back('{ROW_ITEM, 32'h0, it, 1'b0, '0});
  endtask

  task automatic add_typed(in_item_t it, out_item_t r);
    dir_rows.push_back('{ROW_ITEM, 32'h0, it, 1'b1, r});
  endtask

  // Offer one transaction, then record its expected result once accepted
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_item(it);
    pending_results.push_back(typed ? typed_res : predicted);
    if (it.mode == MODE_READ) reads_sent++;
    else convs_sent++;
  endtask

  // APB write of the mask followed by a read back
  task automatic write_mask(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ENABLED_MASK_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mask_model = value[MASK_BITS-1:0];
    mask_settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_BITS'(value[MASK_BITS-1:0])) begin
      errors++;
      $display("%0t: mask read back mismatch, expected %h, got %h",
               $time, PDATA_BITS'(value[MASK_BITS-1:0]), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until the block is idle, then change the mask
  task automatic quiesce_and_write(logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_mask(value);
  endtask

  // Stimulus
  initial begin
    logic [31:0] m;
    int unsigned n;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    mask_model = '0;
    scan_model = 0;
    slot_model = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) hist_model[c][k] = '0;
    end

    // Directed table
    add_typed(rd(0), '0);
    add_typed(conv(10'h3ff), '0);                        // nothing enabled: dropped
    add_typed(rd(4'd15), out_item_t'{4'd15, 10'd0, 10'd0, 1'b0, 1'b0});
    add_cfg(32'h5a5a_ffff);
    add_typed(conv(10'h3ff), out_item_t'{4'd0, 10'h3ff, 10'd0, 1'b1, 1'b0});
    add_typed(conv(10'h000), out_item_t'{4'd1, 10'h000, 10'd0, 1'b1, 1'b0});
    add_typed(rd(0), out_item_t'{4'd0, 10'd0, 10'd127, 1'b1, 1'b0});
    add_cfg(32'h0000_8000);                              // mask change mid-round
    add_typed(conv(10'h3ff), out_item_t'{4'd15, 10'h3ff, 10'd0, 1'b1, 1'b1});
    add_item(conv(10'h155));
    add_item(rd(4'd15));
    add_typed(rd(0), '0);                                // disabled channel
    add_cfg(32'h0000_00f0);
    add_item(conv(10'h2aa));
    add_cfg(32'hffff_0003);                              // nothing above: wrap, no advance
    add_typed(conv(10'h001), out_item_t'{4'd0, 10'h001, 10'd0, 1'b1, 1'b0});
    add_cfg(32'h0000_0001);
    repeat (HISTORY_DEPTH) add_item(conv(10'h3ff));
    add_typed(rd(0), out_item_t'{4'd0, 10'd0, 10'd1023, 1'b1, 1'b0});
    add_cfg(32'h0000_0000);
    add_typed(rd(0), '0);
    add_cfg(32'h0000_0001);                              // history survives re-enable
    add_typed(rd(0), out_item_t'{4'd0, 10'd0, 10'd1023, 1'b1, 1'b0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) quiesce_and_write(dir_rows[i].cfg);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_res);
    end

    // Random part: three idling phases, each through six mask settings
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 9 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        m = $urandom() & 32'hffff_0000;
        case (seg)
          0: m[15:0] = 16'hffff;
          1: m[15:0] = 16'h0001;
          2: m[15:0] = 16'h8000;
          3: m[15:0] = 16'h0000;
          4: m[15:0] = 16'($urandom());
          default: m[15:0] = 16'($urandom() & $urandom());
        endcase
        quiesce_and_write(m);
        n = (seg == 3) ? ZERO_SEG_ITEMS : SEG_ITEMS;
        repeat (n) send_item(random_item(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) errors++;

    $display("Run covered %0d conversions and %0d average reads over %0d mask settings,",
             convs_sent, reads_sent, mask_settings);
    $display("with %0d results checked under sender and receiver stalls.", results_seen);
    if (errors == 0) begin
      $display("adc_scan_channel_averager_unit_tb OK");
    end else begin
      $display("adc_scan_channel_averager_unit_tb NOT OK");
    end
    $finish;
  end

  // Receiver: random stalls plus two long hold-offs
  initial begin
    int hold_left;
    int hold_idx;
    int hold_at [2];
    hold_left   = 0;
    hold_idx    = 0;
    hold_at[0]  = 100;
    hold_at[1]  = 330;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_idx < 2 && results_seen >= hold_at[hold_idx]) begin
        hold_left = HOLD_CYCLES;
        hold_idx++;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got ch=%0d val=%0d avg=%0d",
                 $time, out_data_o.target_channel, out_data_o.passed_value,
                 out_data_o.average);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o !== want) begin
          errors++;
          $display("%0t: result mismatch, expected ch=%0d val=%0d avg=%0d acc=%0b done=%0b",
                   $time, want.target_channel, want.passed_value, want.average,
                   want.accepted, want.round_done);
          $display("%0t:                  got      ch=%0d val=%0d avg=%0d acc=%0b done=%0b",
                   $time, out_data_o.target_channel, out_data_o.passed_value,
                   out_data_o.average, out_data_o.accepted, out_data_o.round_done);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("adc_scan_channel_averager_unit_tb NOT OK");
      $finish;
    end
  end

endmodule
